// ===== hw/rtl/rpzp_pkg.sv =====
// ----------------------------------------------------------------------------
// rpzp_pkg
// Shared codes, constants and the job record passed from front to back end.
// ----------------------------------------------------------------------------
package rpzp_pkg;

    localparam int IDX_W   = 15;
    localparam int DEPTH_W = 24;
    localparam int CHAR_W  = 8;

    localparam logic [CHAR_W-1:0] DOT_CHAR     = 8'd46;
    localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'd32;
    localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'd10;

    localparam logic [1:0] REQ_CLEAR  = 2'd0;
    localparam logic [1:0] REQ_PLOT   = 2'd1;
    localparam logic [1:0] REQ_READ   = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam logic [2:0] CFG_SIN_A   = 3'd0;
    localparam logic [2:0] CFG_COS_A   = 3'd1;
    localparam logic [2:0] CFG_SIN_B   = 3'd2;
    localparam logic [2:0] CFG_COS_B   = 3'd3;
    localparam logic [2:0] CFG_SIN_C   = 3'd4;
    localparam logic [2:0] CFG_COS_C   = 3'd5;
    localparam logic [2:0] CFG_CAM_D   = 3'd6;
    localparam logic [2:0] CFG_HALF_W  = 3'd7;

    typedef enum logic [1:0] {
        JOB_NONE,
        JOB_CLEAR,
        JOB_PLOT,
        JOB_READ
    } job_kind_t;

    typedef struct packed {
        job_kind_t             kind;
        logic [IDX_W-1:0]      idx;
        logic [DEPTH_W-1:0]    depth;
        logic [CHAR_W-1:0]     glyph;
        logic                  edge_hit;
        logic                  col_zero;
    } job_t;

endpackage

// ===== hw/rtl/rpzp_div.sv =====
// ----------------------------------------------------------------------------
// rpzp_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rpzp_div #(
    parameter int NW = 50,
    parameter int DW = 39
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [NW-1:0] quotient,
    output logic [DW-1:0] remainder
);

    localparam int CNT_W = $clog2(NW);

    logic [DW-1:0]    rem_reg;
    logic [NW-1:0]    quo_reg;
    logic [DW-1:0]    dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg;
    logic             done_reg;
    logic [DW:0]      trial;
    logic             fits;

    assign trial = {rem_reg, quo_reg[NW-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(NW - 1);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (run_reg)
        begin
            rem_reg <= fits ? DW'(trial - {1'b0, dvs_reg}) : trial[DW-1:0];
            quo_reg <= {quo_reg[NW-2:0], fits};
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== hw/rtl/rpzp_front.sv =====
// ----------------------------------------------------------------------------
// rpzp_front
// Accepts requests, rotates and projects plot points, builds jobs.
// ----------------------------------------------------------------------------
module rpzp_front #(
    parameter int W  = 160,
    parameter int H  = 44,
    parameter int PS = 40
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_addr,
    input  logic [15:0]        cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         req_type,
    input  logic signed [6:0]  point_x,
    input  logic signed [6:0]  point_y,
    input  logic signed [6:0]  point_z,
    input  logic [7:0]         glyph,
    input  logic [12:0]        cell_index,
    input  logic               init_done,
    input  logic               full,
    output logic               push,
    output rpzp_pkg::job_t     job
);

    localparam int XW    = 41;
    localparam int ZW    = 40;
    localparam int NW    = 50;
    localparam int DW    = 39;
    localparam int CW    = 52;
    localparam int IW    = 62;
    localparam int CELLS = W * H;

    typedef enum logic [6:0] {
        F_IDLE = 7'b0000001,
        F_MUL  = 7'b0000010,
        F_ZCHK = 7'b0000100,
        F_DCOL = 7'b0001000,
        F_DROW = 7'b0010000,
        F_IDX  = 7'b0100000,
        F_PUSH = 7'b1000000
    } fstate_t;

    fstate_t state_reg;

    logic signed [15:0] sin_a_reg, cos_a_reg, sin_b_reg, cos_b_reg, sin_c_reg, cos_c_reg;
    logic [7:0]         cam_reg;
    logic [5:0]         hw_reg;

    logic signed [6:0]  pi_reg, pj_reg, pk_reg;
    logic [7:0]         glyph_reg;
    logic               edge_reg;
    logic [3:0]         step_reg;
    logic signed [31:0] u_reg, v_reg, p1_reg, p2_reg, p3_reg;
    logic signed [63:0] acc_reg, prod_reg;
    logic signed [XW-1:0] xr_reg, yr_reg;
    logic signed [ZW-1:0] zf_reg;
    logic signed [CW-1:0] col_reg, row_reg;
    logic               neg_reg;
    rpzp_pkg::job_t     job_reg;

    logic signed [31:0] opa, opb;
    logic signed [63:0] prod_c;
    logic [6:0]         ax, ay, az, hw7;
    logic               edge_c, col_zero_c, in_fire;
    logic signed [NW:0] num_c;
    logic               div_start, div_done;
    logic [NW-1:0]      div_num, div_quo;
    logic [DW-1:0]      div_rem;
    logic signed [CW-1:0] qs, q0, base_col, base_row, base, adj;
    logic signed [IW-1:0] idx_c;
    rpzp_pkg::job_t     job_in_c;

    assign in_ready = (state_reg == F_IDLE) && init_done;
    assign in_fire  = in_valid && in_ready;
    assign push     = (state_reg == F_PUSH) && !full;
    assign job      = job_reg;

    // edge test on magnitudes; -64 maps to 64, which never matches
    assign ax  = point_x[6] ? 7'(-point_x) : 7'(point_x);
    assign ay  = point_y[6] ? 7'(-point_y) : 7'(point_y);
    assign az  = point_z[6] ? 7'(-point_z) : 7'(point_z);
    assign hw7 = {1'b0, hw_reg};
    assign edge_c = (ax == hw7 && ay == hw7) || (ax == hw7 && az == hw7)
                 || (ay == hw7 && az == hw7);

    always_comb
    begin
        col_zero_c = 1'b0;
        for (int r = 0; r < H; r++)
        begin
            if ({3'b000, cell_index} == 16'(r * W))
                col_zero_c = 1'b1;
        end
    end

    // job for clear and read requests; plots start empty and fill in later
    always_comb
    begin
        job_in_c = '0;
        case (req_type)
            rpzp_pkg::REQ_CLEAR: job_in_c.kind = rpzp_pkg::JOB_CLEAR;
            rpzp_pkg::REQ_READ:
            begin
                if ({3'b000, cell_index} < 16'(CELLS))
                begin
                    job_in_c.kind     = rpzp_pkg::JOB_READ;
                    job_in_c.idx      = rpzp_pkg::IDX_W'(cell_index);
                    job_in_c.col_zero = col_zero_c;
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        opa = '0;
        opb = '0;
        case (step_reg)
            4'd0:  begin opa = 32'(pj_reg); opb = 32'(sin_a_reg); end
            4'd1:  begin opa = 32'(pk_reg); opb = 32'(cos_a_reg); end
            4'd2:  begin opa = 32'(pj_reg); opb = 32'(cos_a_reg); end
            4'd3:  begin opa = 32'(pk_reg); opb = 32'(sin_a_reg); end
            4'd4:  begin opa = 32'(pi_reg); opb = 32'(cos_b_reg); end
            4'd5:  begin opa = 32'(sin_b_reg); opb = 32'(cos_c_reg); end
            4'd6:  begin opa = 32'(sin_b_reg); opb = 32'(sin_c_reg); end
            4'd7:  begin opa = v_reg;  opb = 32'(sin_c_reg); end
            4'd8:  begin opa = p1_reg; opb = 32'(cos_c_reg); end
            4'd9:  begin opa = u_reg;  opb = p2_reg; end
            4'd10: begin opa = v_reg;  opb = 32'(cos_c_reg); end
            4'd11: begin opa = p1_reg; opb = 32'(sin_c_reg); end
            4'd12: begin opa = u_reg;  opb = p3_reg; end
            4'd13: begin opa = u_reg;  opb = 32'(cos_b_reg); end
            4'd14: begin opa = 32'(pi_reg); opb = 32'(sin_b_reg); end
            default: ;
        endcase
    end

    assign prod_c = opa * opb;

    // numerator for the current projection axis
    assign num_c     = (state_reg == F_ZCHK) ? (NW+1)'(xr_reg) * (NW+1)'(2 * PS)
                                             : (NW+1)'(yr_reg) * (NW+1)'(PS);
    assign div_num   = num_c[NW] ? NW'(-num_c) : NW'(num_c);
    assign div_start = ((state_reg == F_ZCHK) && (zf_reg > 0))
                    || ((state_reg == F_DCOL) && div_done);

    rpzp_div #(.NW(NW), .DW(DW)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_num),
        .divisor   (zf_reg[DW-1:0]),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // truncated (C*z + a) / z from |a| / z: pull the quotient back toward zero
    // when the remainder's sign disagrees with the total
    assign base_col = CW'(W / 2) - CW'({hw_reg, 1'b0});
    assign base_row = CW'(H / 2);
    assign base     = (state_reg == F_DCOL) ? base_col : base_row;
    assign qs       = CW'(div_quo);
    assign q0       = base + (neg_reg ? -qs : qs);
    always_comb
    begin
        adj = q0;
        if (div_rem != '0)
        begin
            if (q0 > 0 && neg_reg)
                adj = q0 - 1;
            else if (q0 < 0 && !neg_reg)
                adj = q0 + 1;
        end
    end

    assign idx_c = IW'(col_reg) + IW'(row_reg) * IW'(W);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sin_a_reg <= '0;
            cos_a_reg <= 16'sd16384;
            sin_b_reg <= '0;
            cos_b_reg <= 16'sd16384;
            sin_c_reg <= '0;
            cos_c_reg <= 16'sd16384;
            cam_reg   <= 8'd100;
            hw_reg    <= 6'd20;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                rpzp_pkg::CFG_SIN_A:  sin_a_reg <= cfg_wdata;
                rpzp_pkg::CFG_COS_A:  cos_a_reg <= cfg_wdata;
                rpzp_pkg::CFG_SIN_B:  sin_b_reg <= cfg_wdata;
                rpzp_pkg::CFG_COS_B:  cos_b_reg <= cfg_wdata;
                rpzp_pkg::CFG_SIN_C:  sin_c_reg <= cfg_wdata;
                rpzp_pkg::CFG_COS_C:  cos_c_reg <= cfg_wdata;
                rpzp_pkg::CFG_CAM_D:  cam_reg   <= cfg_wdata[7:0];
                rpzp_pkg::CFG_HALF_W: hw_reg    <= cfg_wdata[5:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                F_IDLE:
                begin
                    step_reg <= '0;
                    if (in_fire)
                        state_reg <= (req_type == rpzp_pkg::REQ_PLOT) ? F_MUL : F_PUSH;
                end
                F_MUL:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 4'd15)
                        state_reg <= F_ZCHK;
                end
                F_ZCHK: state_reg <= (zf_reg > 0) ? F_DCOL : F_PUSH;
                F_DCOL: if (div_done) state_reg <= F_DROW;
                F_DROW: if (div_done) state_reg <= F_IDX;
                F_IDX:  state_reg <= F_PUSH;
                F_PUSH: if (!full) state_reg <= F_IDLE;
                default: state_reg <= F_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            pi_reg    <= point_x;
            pj_reg    <= point_y;
            pk_reg    <= point_z;
            glyph_reg <= glyph;
            edge_reg  <= edge_c;
            job_reg   <= job_in_c;
        end

        if (state_reg == F_MUL)
        begin
            prod_reg <= prod_c;
            case (step_reg)
                4'd1:  acc_reg <= prod_reg;
                4'd2:  u_reg   <= 32'(acc_reg - prod_reg);
                4'd3:  acc_reg <= prod_reg;
                4'd4:  v_reg   <= 32'(acc_reg + prod_reg);
                4'd5:  p1_reg  <= 32'(prod_reg);
                4'd6:  p2_reg  <= 32'(prod_reg);
                4'd7:  p3_reg  <= 32'(prod_reg);
                4'd8:  acc_reg <= prod_reg;
                4'd9:  acc_reg <= acc_reg + prod_reg;
                4'd10: xr_reg  <= XW'(acc_reg + (prod_reg >>> 14));
                4'd11: acc_reg <= prod_reg;
                4'd12: acc_reg <= acc_reg - prod_reg;
                4'd13: yr_reg  <= XW'(acc_reg + ((-prod_reg) >>> 14));
                4'd14: acc_reg <= -prod_reg;
                4'd15: zf_reg  <= ZW'(acc_reg + (prod_reg <<< 14) + (64'(cam_reg) << 28));
                default: ;
            endcase
        end

        if (div_start)
            neg_reg <= num_c[NW];

        if (state_reg == F_DCOL && div_done)
            col_reg <= adj;
        if (state_reg == F_DROW && div_done)
            row_reg <= adj;

        if (state_reg == F_IDX && idx_c >= 0 && idx_c < IW'(CELLS))
            job_reg <= {rpzp_pkg::JOB_PLOT, rpzp_pkg::IDX_W'(idx_c),
                        zf_reg[14 +: rpzp_pkg::DEPTH_W], glyph_reg, edge_reg, 1'b0};
    end

endmodule

// ===== hw/rtl/rpzp_fifo.sv =====
// ----------------------------------------------------------------------------
// rpzp_fifo
// Two-entry job queue between the front and back ends.
// ----------------------------------------------------------------------------
module rpzp_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  rpzp_pkg::job_t push_job,
    input  logic           pop,
    output rpzp_pkg::job_t head,
    output logic           full,
    output logic           empty
);

    rpzp_pkg::job_t slot_reg [2];
    logic           wptr_reg, rptr_reg;
    logic [1:0]     count_reg;

    assign full  = count_reg == 2'd2;
    assign empty = count_reg == 2'd0;
    assign head  = slot_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wptr_reg <= ~wptr_reg;
            if (pop)
                rptr_reg <= ~rptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wptr_reg] <= push_job;
    end

endmodule

// ===== hw/rtl/rpzp_back.sv =====
// ----------------------------------------------------------------------------
// rpzp_back
// Screen memory: clearing sweeps, depth-tested plot writes, cell reads.
// ----------------------------------------------------------------------------
module rpzp_back #(
    parameter int W = 160,
    parameter int H = 44
) (
    input  logic           clk,
    input  logic           rst_n,
    input  rpzp_pkg::job_t head,
    input  logic           empty,
    output logic           pop,
    output logic           init_done,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [7:0]     cell_char,
    output logic           on_screen,
    output logic           glyph_written,
    output logic           edge_marked
);

    localparam int CELLS = W * H;
    localparam int AW    = $clog2(CELLS);
    localparam int MW    = rpzp_pkg::CHAR_W + rpzp_pkg::DEPTH_W + 1;

    typedef enum logic [5:0] {
        B_INIT = 6'b000001,
        B_IDLE = 6'b000010,
        B_CLR  = 6'b000100,
        B_RD   = 6'b001000,
        B_CHK  = 6'b010000,
        B_OUT  = 6'b100000
    } bstate_t;

    bstate_t        state_reg;
    logic [AW-1:0]  sweep_reg;
    logic           init_done_reg;
    rpzp_pkg::job_t job_reg;
    logic [7:0]     char_reg;
    logic           on_reg, wr_reg, mark_reg;

    logic [MW-1:0]  mem [CELLS];
    logic [MW-1:0]  rd_reg;

    logic [7:0]     old_char;
    logic [23:0]    old_depth;
    logic           old_edge, pass;
    logic           we;
    logic [AW-1:0]  waddr;
    logic [MW-1:0]  wdata;
    logic           sweep_last;

    assign {old_char, old_depth, old_edge} = rd_reg;
    assign pass       = (job_reg.depth > old_depth) && !old_edge;
    assign sweep_last = sweep_reg == AW'(CELLS - 1);

    always_comb
    begin
        we    = 1'b0;
        waddr = sweep_reg;
        wdata = {rpzp_pkg::SPACE_CHAR, {rpzp_pkg::DEPTH_W{1'b0}}, 1'b0};
        if (state_reg == B_INIT || state_reg == B_CLR)
            we = 1'b1;
        else if (state_reg == B_CHK && job_reg.kind == rpzp_pkg::JOB_PLOT)
        begin
            we    = 1'b1;
            waddr = job_reg.idx[AW-1:0];
            wdata = {job_reg.edge_hit ? rpzp_pkg::DOT_CHAR : (pass ? job_reg.glyph : old_char),
                     pass ? job_reg.depth : old_depth,
                     old_edge | job_reg.edge_hit};
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rd_reg <= mem[job_reg.idx[AW-1:0]];
    end

    assign pop           = (state_reg == B_IDLE) && !empty;
    assign init_done     = init_done_reg;
    assign out_valid     = state_reg == B_OUT;
    assign cell_char     = char_reg;
    assign on_screen     = on_reg;
    assign glyph_written = wr_reg;
    assign edge_marked   = mark_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_INIT;
            sweep_reg     <= '0;
            init_done_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                B_INIT:
                begin
                    sweep_reg <= sweep_reg + 1'b1;
                    if (sweep_last)
                    begin
                        init_done_reg <= 1'b1;
                        state_reg     <= B_IDLE;
                    end
                end
                B_IDLE:
                begin
                    sweep_reg <= '0;
                    if (!empty)
                    begin
                        case (head.kind)
                            rpzp_pkg::JOB_CLEAR: state_reg <= B_CLR;
                            rpzp_pkg::JOB_PLOT:  state_reg <= B_RD;
                            rpzp_pkg::JOB_READ:  state_reg <= head.col_zero ? B_OUT : B_RD;
                            default:             state_reg <= B_OUT;
                        endcase
                    end
                end
                B_CLR:
                begin
                    sweep_reg <= sweep_reg + 1'b1;
                    if (sweep_last)
                        state_reg <= B_OUT;
                end
                B_RD:  state_reg <= B_CHK;
                B_CHK: state_reg <= B_OUT;
                B_OUT: if (out_ready) state_reg <= B_IDLE;
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg  <= head;
            char_reg <= (head.kind == rpzp_pkg::JOB_READ && head.col_zero)
                        ? rpzp_pkg::NEWLINE_CHAR : 8'd0;
            on_reg   <= 1'b0;
            wr_reg   <= 1'b0;
            mark_reg <= 1'b0;
        end
        else if (state_reg == B_CHK)
        begin
            if (job_reg.kind == rpzp_pkg::JOB_PLOT)
            begin
                on_reg   <= 1'b1;
                wr_reg   <= pass;
                mark_reg <= job_reg.edge_hit;
            end
            else
                char_reg <= old_char;
        end
    end

endmodule

// ===== hw/rtl/rotate_project_zbuffer_plot.sv =====
// ----------------------------------------------------------------------------
// rotate_project_zbuffer_plot
// Rotating point plotter with character screen, depth store and edge marks.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_ready (clear, plot, read); each request
//   gives exactly one result on out_valid/out_ready. Configuration writes
//   go through cfg_we/cfg_addr/cfg_wdata; the user must make them only
//   while the block is idle, which the block itself does not enforce.
//   A plot passes the shared 32x32 multiplier for the rotation, two
//   bit-serial divisions (column, row) unless the point is behind the
//   camera, then a read-modify-write of one screen cell if it lands on
//   screen. The front end takes a new request only after it has pushed
//   the job for the last one. A read result is fetched from the screen
//   memory; a column-zero, out-of-range or unused request skips the
//   memory. A clear sweeps the screen memory one cell per cycle.
//   The front end takes the next request while the back end still works
//   through the two-entry job queue.
//   After reset the screen memory is swept to spaces, zero depth and no
//   marks; in_ready stays low until the sweep is done. A stalled receiver
//   holds the result; the queue fills and then in_ready drops.
// ----------------------------------------------------------------------------
module rotate_project_zbuffer_plot #(
    parameter int SCREEN_WIDTH     = 160,
    parameter int SCREEN_HEIGHT    = 44,
    parameter int PROJECTION_SCALE = 40
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_addr,
    input  logic [15:0]       cfg_wdata,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        req_type,
    input  logic signed [6:0] point_x,
    input  logic signed [6:0] point_y,
    input  logic signed [6:0] point_z,
    input  logic [7:0]        glyph,
    input  logic [12:0]       cell_index,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        cell_char,
    output logic              on_screen,
    output logic              glyph_written,
    output logic              edge_marked
);

    rpzp_pkg::job_t push_job, head;
    logic           push, pop, full, empty, init_done;

    rpzp_front #(
        .W  (SCREEN_WIDTH),
        .H  (SCREEN_HEIGHT),
        .PS (PROJECTION_SCALE)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .point_x    (point_x),
        .point_y    (point_y),
        .point_z    (point_z),
        .glyph      (glyph),
        .cell_index (cell_index),
        .init_done  (init_done),
        .full       (full),
        .push       (push),
        .job        (push_job)
    );

    rpzp_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .full     (full),
        .empty    (empty)
    );

    rpzp_back #(
        .W (SCREEN_WIDTH),
        .H (SCREEN_HEIGHT)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .empty         (empty),
        .pop           (pop),
        .init_done     (init_done),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .cell_char     (cell_char),
        .on_screen     (on_screen),
        .glyph_written (glyph_written),
        .edge_marked   (edge_marked)
    );

    a_no_accept_before_init: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> init_done)
        else $error("request taken before memory sweep finished");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("job pushed into full queue");

    a_flags_need_screen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (glyph_written || edge_marked) |-> on_screen)
        else $error("plot flag set without on-screen cell");

    a_plot_has_no_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && on_screen |-> cell_char == 8'd0)
        else $error("plot result carries a character");

endmodule

// ===== tb/tb_rotate_project_zbuffer_plot.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rotate_project_zbuffer_plot
// Self-checking bench: a queue-fed driver pushes clear, plot and read
// requests while a monitor compares every result with a local depth-buffer
// model, across several rotation, camera and cube-size settings.
// ----------------------------------------------------------------------------
module tb_rotate_project_zbuffer_plot;

    localparam int SCR_W    = 160;
    localparam int SCR_H    = 44;
    localparam int PROJ_K   = 40;
    localparam int NCELLS   = SCR_W * SCR_H;
    localparam int MAX_CYC  = 3000000;
    localparam int N_RANDOM = 225;

    typedef struct packed {
        logic [1:0]        kind;
        logic signed [6:0] x;
        logic signed [6:0] y;
        logic signed [6:0] z;
        logic [7:0]        g;
        logic [12:0]       cell_idx;
    } plot_req_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       on;
        logic       gw;
        logic       em;
    } plot_res_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [15:0] cfg_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  req_type = '0;
    logic signed [6:0] point_x = '0;
    logic signed [6:0] point_y = '0;
    logic signed [6:0] point_z = '0;
    logic [7:0]  glyph = '0;
    logic [12:0] cell_index = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  cell_char;
    logic        on_screen;
    logic        glyph_written;
    logic        edge_marked;

    rotate_project_zbuffer_plot u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready),
        .req_type(req_type), .point_x(point_x), .point_y(point_y),
        .point_z(point_z), .glyph(glyph), .cell_index(cell_index),
        .out_valid(out_valid), .out_ready(out_ready),
        .cell_char(cell_char), .on_screen(on_screen),
        .glyph_written(glyph_written), .edge_marked(edge_marked)
    );

    always #4 clk = ~clk;

    // Screen model and register copies
    logic [7:0]  screen_chars [NCELLS];
    logic [23:0] screen_depth [NCELLS];
    logic        screen_edges [NCELLS];
    logic signed [15:0] m_sin_a = 16'sd0, m_cos_a = 16'sd16384;
    logic signed [15:0] m_sin_b = 16'sd0, m_cos_b = 16'sd16384;
    logic signed [15:0] m_sin_c = 16'sd0, m_cos_c = 16'sd16384;
    logic [7:0]  m_cam = 8'd100;
    logic [5:0]  m_half = 6'd20;

    plot_req_t pending_reqs [$];
    plot_res_t expected_results [$];
    int send_idle = 10;
    int recv_idle = 72;
    int mismatches = 0;
    int cycles = 0;
    logic took = 1'b0;

    function automatic void wipe_screen();
        for (int n = 0; n < NCELLS; n++)
        begin
            screen_chars[n] = rpzp_pkg::SPACE_CHAR;
            screen_depth[n] = '0;
            screen_edges[n] = 1'b0;
        end
    endfunction

    function automatic plot_res_t apply_request(plot_req_t r);
        longint i, j, k, sa, ca, sb, cb, sc, cc, hw;
        longint x42, y42, xr, yr, zr, zf, col, row, idx;
        logic [23:0] dq;
        plot_res_t res;
        res = '0;
        if (r.kind == rpzp_pkg::REQ_CLEAR)
            wipe_screen();
        else if (r.kind == rpzp_pkg::REQ_READ)
        begin
            if (r.cell_idx < NCELLS)
                res.ch = (r.cell_idx % SCR_W == 0) ? rpzp_pkg::NEWLINE_CHAR
                                                   : screen_chars[r.cell_idx];
        end
        else if (r.kind == rpzp_pkg::REQ_PLOT)
        begin
            i = longint'(r.x); j = longint'(r.y); k = longint'(r.z);
            sa = longint'(m_sin_a); ca = longint'(m_cos_a); sb = longint'(m_sin_b);
            cb = longint'(m_cos_b); sc = longint'(m_sin_c); cc = longint'(m_cos_c);
            x42 = j * sa * sb * cc - k * ca * sb * cc
                + (j * ca * sc + k * sa * sc + i * cb * cc) * 16384;
            y42 = (j * ca * cc + k * sa * cc - i * cb * sc) * 16384
                - j * sa * sb * sc + k * ca * sb * sc;
            xr = x42 >>> 14;
            yr = y42 >>> 14;
            zr = k * ca * cb - j * sa * cb + i * sb * 16384;
            zf = zr + longint'(m_cam) * (64'sd1 << 28);
            if (zf > 0)
            begin
                hw = longint'(m_half);
                col = ((SCR_W / 2 - 2 * hw) * zf + 2 * PROJ_K * xr) / zf;
                row = ((SCR_H / 2) * zf + PROJ_K * yr) / zf;
                idx = col + row * SCR_W;
                if (idx >= 0 && idx < NCELLS)
                begin
                    res.on = 1'b1;
                    dq = zf[37:14];
                    if (dq > screen_depth[idx] && !screen_edges[idx])
                    begin
                        screen_depth[idx] = dq;
                        screen_chars[idx] = r.g;
                        res.gw = 1'b1;
                    end
                    if (i < 0) i = -i;
                    if (j < 0) j = -j;
                    if (k < 0) k = -k;
                    if ((i == hw && j == hw) || (i == hw && k == hw) || (j == hw && k == hw))
                    begin
                        screen_chars[idx] = rpzp_pkg::DOT_CHAR;
                        screen_edges[idx] = 1'b1;
                        res.em = 1'b1;
                    end
                end
            end
        end
        return res;
    endfunction

    // Driver: new items and receiver stalls change on the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !took)
            begin
                // hold until transfer
            end
            else if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle)
            begin
                plot_req_t r;
                r = pending_reqs.pop_front();
                req_type   <= r.kind;
                point_x    <= r.x;
                point_y    <= r.y;
                point_z    <= r.z;
                glyph      <= r.g;
                cell_index <= r.cell_idx;
                in_valid   <= 1'b1;
            end
            else
                in_valid <= 1'b0;
            out_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Monitor: predict on input transfer, check on output transfer
    always @(posedge clk)
    begin
        took = in_valid && in_ready;
        if (took)
            expected_results.push_back(apply_request({req_type, point_x, point_y,
                                                      point_z, glyph, cell_index}));
        if (out_valid && out_ready)
        begin
            plot_res_t got, want;
            got = {cell_char, on_screen, glyph_written, edge_marked};
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", got);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: char %0d/%0d on %b/%b written %b/%b edge %b/%b",
                                 want.ch, got.ch, want.on, got.on, want.gw, got.gw,
                                 want.em, got.em);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > MAX_CYC)
        begin
            $display("FAIL rotate_project_zbuffer_plot");
            $finish;
        end
    end

    task automatic add_req(input logic [1:0] kind, input int x, input int y, input int z,
                           input int g, input int cell_idx);
        plot_req_t r;
        r.kind = kind;
        r.x = 7'(x); r.y = 7'(y); r.z = 7'(z);
        r.g = 8'(g);
        r.cell_idx = 13'(cell_idx);
        pending_reqs.push_back(r);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [15:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        case (addr)
            rpzp_pkg::CFG_SIN_A:  m_sin_a = data;
            rpzp_pkg::CFG_COS_A:  m_cos_a = data;
            rpzp_pkg::CFG_SIN_B:  m_sin_b = data;
            rpzp_pkg::CFG_COS_B:  m_cos_b = data;
            rpzp_pkg::CFG_SIN_C:  m_sin_c = data;
            rpzp_pkg::CFG_COS_C:  m_cos_c = data;
            rpzp_pkg::CFG_CAM_D:  m_cam = data[7:0];
            default:              m_half = data[5:0];
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_angles();
        real a;
        for (int n = 0; n < 3; n++)
        begin
            a = $urandom_range(0, 62831) / 10000.0;
            write_reg(3'(2 * n), 16'($rtoi($sin(a) * 16384.0)));
            write_reg(3'(2 * n + 1), 16'($rtoi($cos(a) * 16384.0)));
        end
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic add_random_reqs(input int count);
        int pick, hw, a, b, c;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            hw = int'(m_half);
            if (pick < 1)
                add_req(rpzp_pkg::REQ_CLEAR, 0, 0, 0, 0, 0);
            else if (pick < 3)
                add_req(rpzp_pkg::REQ_UNUSED, $urandom, $urandom, $urandom, $urandom,
                        $urandom);
            else if (pick < 30)
            begin
                if ($urandom_range(1))
                    add_req(rpzp_pkg::REQ_READ, $urandom, $urandom, $urandom, $urandom,
                            $urandom_range(0, 8191));
                else
                    add_req(rpzp_pkg::REQ_READ, 0, 0, 0, 0,
                            $urandom_range(14, 30) * SCR_W + $urandom_range(0, SCR_W - 1));
            end
            else if (pick < 45)
            begin
                // two coordinates on the cube surface edges
                a = $urandom_range(1) ? hw : -hw;
                b = $urandom_range(1) ? hw : -hw;
                c = $urandom_range(0, 2 * hw) - hw;
                case ($urandom_range(2))
                    0: add_req(rpzp_pkg::REQ_PLOT, a, b, c, $urandom, 0);
                    1: add_req(rpzp_pkg::REQ_PLOT, a, c, b, $urandom, 0);
                    default: add_req(rpzp_pkg::REQ_PLOT, c, a, b, $urandom, 0);
                endcase
            end
            else if (pick < 80)
                add_req(rpzp_pkg::REQ_PLOT, $urandom_range(0, 2 * hw) - hw,
                        $urandom_range(0, 2 * hw) - hw,
                        $urandom_range(0, 2 * hw) - hw, $urandom, 0);
            else
                add_req(rpzp_pkg::REQ_PLOT, $urandom, $urandom, $urandom, $urandom, 0);
        end
    endtask

    initial
    begin
        wipe_screen();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: default setting centers the origin at column 40, row 22
        add_req(rpzp_pkg::REQ_CLEAR, 0, 0, 0, 0, 0);
        add_req(rpzp_pkg::REQ_PLOT, 0, 0, 0, 8'h41, 0);
        add_req(rpzp_pkg::REQ_PLOT, 0, 0, 0, 8'h5A, 0);
        add_req(rpzp_pkg::REQ_PLOT, 0, 0, 10, 8'h42, 0);
        add_req(rpzp_pkg::REQ_PLOT, 0, 0, -10, 8'h43, 0);
        add_req(rpzp_pkg::REQ_READ, 0, 0, 0, 0, 3560);
        add_req(rpzp_pkg::REQ_PLOT, 20, 20, 0, 8'h45, 0);
        add_req(rpzp_pkg::REQ_PLOT, 20, 20, 30, 8'hFF, 0);
        add_req(rpzp_pkg::REQ_PLOT, -20, 20, 5, 8'h00, 0);
        add_req(rpzp_pkg::REQ_PLOT, 63, 63, 63, 8'h80, 0);
        add_req(rpzp_pkg::REQ_PLOT, -64, -64, -64, 8'h7F, 0);
        add_req(rpzp_pkg::REQ_PLOT, 63, -64, 0, 8'h55, 0);
        add_req(rpzp_pkg::REQ_READ, 0, 0, 0, 0, 0);
        add_req(rpzp_pkg::REQ_READ, 0, 0, 0, 0, NCELLS - 1);
        add_req(rpzp_pkg::REQ_READ, 0, 0, 0, 0, NCELLS);
        add_req(rpzp_pkg::REQ_READ, 0, 0, 0, 0, 8191);
        add_req(rpzp_pkg::REQ_UNUSED, -1, -1, -1, 255, 8191);
        add_req(rpzp_pkg::REQ_READ, 0, 0, 0, 0, 3561);
        add_req(rpzp_pkg::REQ_CLEAR, 0, 0, 0, 0, 0);
        add_req(rpzp_pkg::REQ_READ, 0, 0, 0, 0, 3560);

        for (int p = 0; p < 6; p++)
        begin
            send_idle = (p < 2) ? 10 : (p < 4) ? 72 : 0;
            recv_idle = (p < 2) ? 72 : (p < 4) ? 10 : 0;
            if (p > 0)
                wait_drained();
            case (p)
                1:
                begin
                    // extremes; a point far back at x=-64 reaches the camera plane and is not projected
                    write_reg(rpzp_pkg::CFG_SIN_A, -16'sd16384);
                    write_reg(rpzp_pkg::CFG_COS_A, 16'sd0);
                    write_reg(rpzp_pkg::CFG_SIN_B, 16'sd16384);
                    write_reg(rpzp_pkg::CFG_COS_B, 16'sd0);
                    write_reg(rpzp_pkg::CFG_SIN_C, 16'sd16384);
                    write_reg(rpzp_pkg::CFG_COS_C, -16'sd16384);
                    write_reg(rpzp_pkg::CFG_CAM_D, 16'd64);
                    write_reg(rpzp_pkg::CFG_HALF_W, 16'd1);
                    add_req(rpzp_pkg::REQ_PLOT, -64, 0, 0, 8'h21, 0);
                    add_req(rpzp_pkg::REQ_PLOT, -64, 63, -64, 8'h22, 0);
                    add_req(rpzp_pkg::REQ_PLOT, -63, 1, 1, 8'h23, 0);
                    add_req(rpzp_pkg::REQ_PLOT, 1, -1, 5, 8'h24, 0);
                end
                2:
                begin
                    write_angles();
                    write_reg(rpzp_pkg::CFG_CAM_D, 16'd255);
                    write_reg(rpzp_pkg::CFG_HALF_W, 16'd32);
                end
                3:
                begin
                    // raw bit patterns outside the nominal ranges
                    for (int n = 0; n < 8; n++)
                        write_reg(3'(n), 16'($urandom));
                    if (m_cam < 8'd64)
                        write_reg(rpzp_pkg::CFG_CAM_D, 16'd64);
                end
                4:
                begin
                    write_angles();
                    write_reg(rpzp_pkg::CFG_CAM_D, 16'($urandom_range(64, 255)));
                    write_reg(rpzp_pkg::CFG_HALF_W, 16'($urandom_range(1, 32)));
                end
                5:
                begin
                    write_angles();
                    write_reg(rpzp_pkg::CFG_CAM_D, 16'd100);
                    write_reg(rpzp_pkg::CFG_HALF_W, 16'd20);
                end
                default: ;
            endcase
            add_random_reqs(N_RANDOM);
        end

        wait_drained();
        repeat (200) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("PASS rotate_project_zbuffer_plot");
        else
            $display("FAIL rotate_project_zbuffer_plot");
        $finish;
    end

endmodule
